/* rtl/efi_pkg.sv */
package efi_pkg;

  localparam int unsigned IMAGE_WIDTH  = 1024;
  localparam int unsigned IMAGE_HEIGHT = 1024;
  localparam int unsigned DIM_W        = 13;

  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned Q_W       = 32;
  localparam int unsigned PIX_W     = 10;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned MODE_W    = 2;

  localparam logic [63:0] ESCAPE_Q856 = 64'h0400_0000_0000_0000;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM = 3'd7;

  localparam logic [MODE_W-1:0] MODE_MANDEL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_JULIA  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHIP   = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } efi_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_x;
    logic [PIX_W-1:0] out_y;
    logic [CNT_W-1:0] iterations;
  } efi_out_t;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [CNT_W-1:0]      iteration_limit;
    logic signed [Q_W-1:0] x_origin;
    logic signed [Q_W-1:0] y_origin;
    logic signed [Q_W-1:0] x_step;
    logic signed [Q_W-1:0] y_step;
    logic signed [Q_W-1:0] julia_c_real;
    logic signed [Q_W-1:0] julia_c_imag;
  } efi_cfg_t;

  // one classified pixel, ready for the iteration engine
  typedef struct packed {
    logic [PIX_W-1:0]      px;
    logic [PIX_W-1:0]      py;
    logic signed [Q_W-1:0] zr;
    logic signed [Q_W-1:0] zi;
    logic signed [Q_W-1:0] cr;
    logic signed [Q_W-1:0] ci;
    logic                  ship;
    logic                  skip;
  } efi_job_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] v);
    logic signed [63:0] qmax;
    logic signed [63:0] qmin;
    qmax = 64'sh0000_0000_7FFF_FFFF;
    qmin = -64'sh0000_0000_8000_0000;
    if (v > qmax) begin
      sat_q = 32'sh7FFF_FFFF;
    end else if (v < qmin) begin
      sat_q = 32'sh8000_0000;
    end else begin
      sat_q = v[Q_W-1:0];
    end
  endfunction

  // -8.0 maps to the largest positive value
  function automatic logic signed [Q_W-1:0] abs_q(input logic signed [Q_W-1:0] v);
    if (!v[Q_W-1]) begin
      abs_q = v;
    end else if (v == 32'sh8000_0000) begin
      abs_q = 32'sh7FFF_FFFF;
    end else begin
      abs_q = -v;
    end
  endfunction

endpackage

/* rtl/escape_time_fractal_iterator_top.sv */
// escape-time fractal iterator (mandelbrot, julia, burning ship)
// input side is a queue: in_item_i carries pixel_x/pixel_y and is taken on
// a clock edge with push high and full low. result side is a single result
// register: out_item_o holds the result while empty is low and is taken on an
// edge with pop high. one result per pixel, in input order.
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
// clock edge; write only while no pixel is in flight.
// processing order after a pixel is accepted: it waits in the job queue, the
// engine loads it, each iteration round passes a multiply state (S_MUL) and
// an update state (S_UPD), and the result register is written when the engine
// leaves S_DONE. the engine runs r rounds, where r is the iteration count, plus
// one round for the final escape test of a pixel that escapes (r = 0 for
// skipped pixels). one pixel is iterated at a time by the single iteration
// engine, whose three 32x32 multipliers are registered before each update.
// a two-entry job queue ahead of the engine keeps accepting pixels while
// the engine works or its result waits for pop; when the receiver stalls the
// engine holds its finished pixel and full rises once the job queue fills.
// reset clears both queues and loads the register defaults (mandelbrot,
// limit 64, origin -2-2i, step 1/256, julia constant zero).
module escape_time_fractal_iterator_top import efi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  efi_in_t              in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output efi_out_t             out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [Q_W-1:0]       cfg_data_i
);

  efi_cfg_t cfg_q;
  efi_job_t front_job;
  efi_job_t queue_job;
  logic     queue_empty;
  logic     job_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode            <= MODE_MANDEL;
      cfg_q.iteration_limit <= 10'd64;
      cfg_q.x_origin        <= 32'shE000_0000;
      cfg_q.y_origin        <= 32'shE000_0000;
      cfg_q.x_step          <= 32'sh0010_0000;
      cfg_q.y_step          <= 32'sh0010_0000;
      cfg_q.julia_c_real    <= '0;
      cfg_q.julia_c_imag    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:     cfg_q.mode            <= cfg_data_i[MODE_W-1:0];
        REG_LIMIT:    cfg_q.iteration_limit <= cfg_data_i[CNT_W-1:0];
        REG_X_ORIGIN: cfg_q.x_origin        <= cfg_data_i;
        REG_Y_ORIGIN: cfg_q.y_origin        <= cfg_data_i;
        REG_X_STEP:   cfg_q.x_step          <= cfg_data_i;
        REG_Y_STEP:   cfg_q.y_step          <= cfg_data_i;
        REG_JULIA_RE: cfg_q.julia_c_real    <= cfg_data_i;
        REG_JULIA_IM: cfg_q.julia_c_imag    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  efi_front u_front (
    .cfg_i  (cfg_q),
    .item_i (in_item_i),
    .job_o  (front_job)
  );

  efi_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (front_job),
    .full_o    (full),
    .rd_i      (job_pop),
    .rd_data_o (queue_job),
    .empty_o   (queue_empty)
  );

  efi_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_empty_i (queue_empty),
    .job_i       (queue_job),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule

/* rtl/efi_front.sv */
module efi_front import efi_pkg::*; (
  input  efi_cfg_t cfg_i,
  input  efi_in_t  item_i,
  output efi_job_t job_o
);

  logic signed [42:0] prod_x;
  logic signed [42:0] prod_y;
  logic signed [43:0] sum_x;
  logic signed [43:0] sum_y;
  logic signed [Q_W-1:0] pr;
  logic signed [Q_W-1:0] pi;
  logic inside_img;

  always_comb begin
    prod_x = $signed({1'b0, item_i.pixel_x}) * cfg_i.x_step;
    prod_y = $signed({1'b0, item_i.pixel_y}) * cfg_i.y_step;
    sum_x  = 44'(prod_x) + 44'(cfg_i.x_origin);
    sum_y  = 44'(prod_y) + 44'(cfg_i.y_origin);
    pr     = sat_q(64'(sum_x));
    pi     = sat_q(64'(sum_y));

    inside_img = ({{(DIM_W-PIX_W){1'b0}}, item_i.pixel_x} < DIM_W'(IMAGE_WIDTH)) &&
                 ({{(DIM_W-PIX_W){1'b0}}, item_i.pixel_y} < DIM_W'(IMAGE_HEIGHT));

    job_o.px   = item_i.pixel_x;
    job_o.py   = item_i.pixel_y;
    job_o.ship = cfg_i.mode[1];
    job_o.skip = !inside_img || (cfg_i.iteration_limit == '0);
    if (cfg_i.mode == MODE_JULIA) begin
      job_o.zr = pr;
      job_o.zi = pi;
      job_o.cr = cfg_i.julia_c_real;
      job_o.ci = cfg_i.julia_c_imag;
    end else begin
      job_o.zr = '0;
      job_o.zi = '0;
      job_o.cr = pr;
      job_o.ci = pi;
    end
  end

endmodule

/* rtl/efi_queue.sv */
module efi_queue import efi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  efi_job_t wr_data_i,
  output logic     full_o,
  input  logic     rd_i,
  output efi_job_t rd_data_o,
  output logic     empty_o
);

  efi_job_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0]   cnt_q, cnt_d;
  logic                     do_wr;
  logic                     do_rd;

  assign full_o    = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* rtl/efi_core.sv */
module efi_core import efi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  efi_cfg_t cfg_i,
  input  logic     job_empty_i,
  input  efi_job_t job_i,
  output logic     job_pop_o,
  input  logic     pop_i,
  output logic     empty_o,
  output efi_out_t out_item_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  res_valid_q, res_valid_d;
  efi_out_t              res_q;
  logic [PIX_W-1:0]      px_q, py_q;
  logic signed [Q_W-1:0] zr_q, zi_q, cr_q, ci_q;
  logic                  ship_q;
  logic signed [63:0]    rr_q, ii_q, ri_q;

  logic [64:0]           mag;
  logic                  escape;
  logic signed [63:0]    diff;
  logic signed [Q_W-1:0] re_t, im_t, re_n, im_n;
  logic signed [Q_W:0]   sum_re, sum_im;
  logic [CNT_W-1:0]      count_inc;
  logic                  res_free;
  logic                  load;
  logic                  finish;

  assign empty_o    = !res_valid_q;
  assign out_item_o = res_q;
  assign res_free   = !res_valid_q || pop_i;
  assign load       = (state_q == S_IDLE) && !job_empty_i;
  assign finish     = (state_q == S_DONE) && res_free;
  assign job_pop_o  = load;
  assign count_inc  = count_q + 1'b1;

  // one iteration step from the registered products
  always_comb begin
    mag    = {1'b0, rr_q} + {1'b0, ii_q};
    escape = (mag >= {1'b0, ESCAPE_Q856});
    diff   = rr_q - ii_q;
    re_t   = sat_q(diff >>> FRAC_BITS);
    im_t   = sat_q(ri_q >>> (FRAC_BITS - 1));
    sum_re = 33'(re_t) + 33'(cr_q);
    sum_im = 33'(im_t) + 33'(ci_q);
    re_n   = sat_q(64'(sum_re));
    im_n   = sat_q(64'(sum_im));
    if (ship_q) begin
      re_n = abs_q(re_n);
      im_n = abs_q(im_n);
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_valid_d = res_valid_q;
    if (pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (load) begin
          count_d = '0;
          state_d = job_i.skip ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (escape) begin
          state_d = S_DONE;
        end else begin
          count_d = count_inc;
          state_d = (count_inc == cfg_i.iteration_limit) ? S_DONE : S_MUL;
        end
      end
      S_DONE: begin
        if (finish) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= job_i.px;
      py_q   <= job_i.py;
      zr_q   <= job_i.zr;
      zi_q   <= job_i.zi;
      cr_q   <= job_i.cr;
      ci_q   <= job_i.ci;
      ship_q <= job_i.ship;
    end else if (state_q == S_UPD && !escape) begin
      zr_q <= re_n;
      zi_q <= im_n;
    end
    if (state_q == S_MUL) begin
      rr_q <= zr_q * zr_q;
      ii_q <= zi_q * zi_q;
      ri_q <= zr_q * zi_q;
    end
    if (finish) begin
      res_q.out_x      <= px_q;
      res_q.out_y      <= py_q;
      res_q.iterations <= count_q;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (count_q <= cfg_i.iteration_limit))
    else $error("iteration count above limit");

  a_mul_then_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> (state_q == S_UPD))
    else $error("multiply not followed by update");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_valid_q && !pop_i) |=> (state_q == S_DONE && res_valid_q))
    else $error("result overwritten while receiver stalls");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> (state_q == S_IDLE && !job_empty_i))
    else $error("job taken while engine busy");

endmodule
